// ----- src/dsrl_pkg.sv -----
// Package for the decimating sample ring logger.
// Holds op and status codes, register indexes and the item types.
`default_nettype none
package dsrl_pkg;
  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_FLUSH  = 3'd1,
    OP_READ   = 3'd2,
    OP_LATEST = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_SKIPPED  = 3'd1,
    ST_ORDER    = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  localparam logic [0:0] REG_INTERVAL  = 1'b0;
  localparam logic [0:0] REG_OVERWRITE = 1'b1;
  localparam int unsigned CfgIdxW = 8;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] sample_timestamp;
    logic [63:0] sample_payload;
    logic [31:0] min_timestamp;
    logic [15:0] item_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_timestamp;
    logic [63:0] out_payload;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_t;

  typedef struct packed {
    logic [31:0] t;
    logic [63:0] p;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_COPY_RD, S_COPY_WR, S_RD_ISSUE, S_RD_CHECK,
    S_LATEST, S_DONE, S_COMMIT_END
  } state_e;
endpackage
`default_nettype wire

// ----- src/dsrl_if.sv -----
// Valid/ready channel interface carrying a typed payload.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface dsrl_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/dsrl_mem.sv -----
// Single-port-write, single-read synchronous memory of sample entries.
// Depends on dsrl_pkg.
`default_nettype none
module dsrl_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [AddrW-1:0]   waddr_i,
  input  wire dsrl_pkg::entry_t   wdata_i,
  input  wire logic [AddrW-1:0]   raddr_i,
  output dsrl_pkg::entry_t        rdata_o
);
  import dsrl_pkg::*;
  entry_t mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- src/decimating_sample_ring_logger_unit.sv -----
// Top level of the decimating sample ring logger.
// Depends on dsrl_pkg, dsrl_if and dsrl_mem.
//
// channel  | dir | payload
// in_ch    | in  | op, sample_timestamp, sample_payload, min_timestamp, item_index
// out_ch   | out | status, out_timestamp, out_payload
// cfg_ch   | in  | register index, write data
//
// One item at a time. The result of a sample, flush, latest time or clear passes
// through decode, done and the output register. A commit adds a copy read step,
// one copy write step per sample copied from the pending memory into the ring
// memory and a commit end step; a sample that retries a held commit is decoded
// again. A read visits each sample in an issue and a check state, with one more
// issue step per block boundary. A result waits in the output register; the next
// item is taken no earlier than the cycle in which that result is handed off.
// No clearing pass after reset.
`default_nettype none
module decimating_sample_ring_logger_unit #(
  parameter int unsigned BLOCK_SLOTS = 8,
  parameter int unsigned SAMPLES_PER_BLOCK = 32
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  dsrl_if.sink     in_ch,
  dsrl_if.source   out_ch,
  dsrl_if.sink     cfg_ch
);
  import dsrl_pkg::*;

  localparam int unsigned SlotW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
  localparam int unsigned PosW  = $clog2(SAMPLES_PER_BLOCK);
  localparam int unsigned FillW = $clog2(SAMPLES_PER_BLOCK + 1);
  localparam int unsigned CntW  = $clog2(BLOCK_SLOTS + 1);
  localparam int unsigned RingW = SlotW + PosW;
  localparam logic [FillW-1:0] FullFill = FillW'(SAMPLES_PER_BLOCK);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(BLOCK_SLOTS - 1);
  localparam logic [CntW-1:0]  MaxBlocks = CntW'(BLOCK_SLOTS);
  localparam logic [CntW:0]    SlotsExt = (CntW+1)'(BLOCK_SLOTS);

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic   out_valid_q, out_valid_d;

  logic [31:0] interval_q;
  logic        overwrite_q;

  logic [FillW-1:0] fill_mem_q [BLOCK_SLOTS];
  logic [31:0]      end_mem_q [BLOCK_SLOTS];
  logic [BLOCK_SLOTS-1:0] present_q, present_d;
  logic [FillW-1:0] pend_fill_q, pend_fill_d;
  logic [SlotW-1:0] wslot_q, wslot_d;
  logic [CntW-1:0]  nblk_q, nblk_d;
  logic [31:0] last_t_q, last_t_d;
  logic        last_v_q, last_v_d;
  logic [31:0] end_t_q, end_t_d;
  logic        end_v_q, end_v_d;
  logic [31:0] pend_last_q, pend_last_d;

  // walk and copy counters
  logic [FillW-1:0] pos_q, pos_d;
  logic [CntW-1:0]  blk_q, blk_d;
  logic [15:0]      idx_q, idx_d;
  logic             retry_q, retry_d;

  logic             pw_we, rw_we;
  logic [PosW-1:0]  pw_addr, pr_addr;
  entry_t           pw_data, pr_data;
  logic [RingW-1:0] rw_addr, rr_addr;
  entry_t           rr_data;
  logic             wr_meta;

  dsrl_mem #(.Depth(SAMPLES_PER_BLOCK), .AddrW(PosW)) u_pend (
    .clk_i, .we_i(pw_we), .waddr_i(pw_addr), .wdata_i(pw_data),
    .raddr_i(pr_addr), .rdata_o(pr_data)
  );
  dsrl_mem #(.Depth(2 ** RingW), .AddrW(RingW)) u_ring (
    .clk_i, .we_i(rw_we), .waddr_i(rw_addr), .wdata_i(pr_data),
    .raddr_i(rr_addr), .rdata_o(rr_data)
  );

  assign in_ch.ready  = (state_q == S_IDLE) && (!out_valid_q || out_ch.ready);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = rsp_q;

  logic [SlotW-1:0] oldest, walk_slot, newest;
  logic [CntW:0]    old_sum, walk_sum;
  logic [FillW-1:0] walk_fill;
  logic             in_pend;
  logic             commit_ok;
  logic [31:0]      walk_t;
  logic [63:0]      walk_p;

  always_comb begin
    old_sum   = {1'b0, CntW'(wslot_q)} + SlotsExt - {1'b0, nblk_q};
    oldest    = (old_sum >= SlotsExt) ? SlotW'(old_sum - SlotsExt) : SlotW'(old_sum);
    walk_sum  = {1'b0, CntW'(oldest)} + {1'b0, blk_q};
    walk_slot = (walk_sum >= SlotsExt) ? SlotW'(walk_sum - SlotsExt) : SlotW'(walk_sum);
    newest    = (wslot_q == '0) ? LastSlot : wslot_q - 1'b1;
    in_pend   = (blk_q == nblk_q);
    walk_fill = in_pend ? pend_fill_q : fill_mem_q[walk_slot];
    walk_t    = in_pend ? pr_data.t : rr_data.t;
    walk_p    = in_pend ? pr_data.p : rr_data.p;
    commit_ok = overwrite_q || !present_q[wslot_q];
  end

  always_comb begin
    state_d = state_q; rsp_d = rsp_q; out_valid_d = out_valid_q;
    present_d = present_q; pend_fill_d = pend_fill_q; wslot_d = wslot_q;
    nblk_d = nblk_q; last_t_d = last_t_q; last_v_d = last_v_q;
    end_t_d = end_t_q; end_v_d = end_v_q; pend_last_d = pend_last_q;
    pos_d = pos_q; blk_d = blk_q; idx_d = idx_q; retry_d = retry_q;
    pw_we = 1'b0; pw_addr = pend_fill_q[PosW-1:0];
    pw_data = '{t: req_q.sample_timestamp, p: req_q.sample_payload};
    pr_addr = pos_q[PosW-1:0];
    rw_we = 1'b0; rw_addr = {wslot_q, pos_q[PosW-1:0]};
    rr_addr = {walk_slot, pos_q[PosW-1:0]};
    wr_meta = 1'b0;
    if (out_ch.valid && out_ch.ready) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        rsp_d = '{status: ST_DONE, out_timestamp: '0, out_payload: '0};
        pos_d = '0; blk_d = '0; idx_d = req_q.item_index; retry_d = 1'b0;
        case (req_q.op)
          OP_SAMPLE: begin
            if ((last_v_q && req_q.sample_timestamp < last_t_q) ||
                (end_v_q && req_q.sample_timestamp < end_t_q)) begin
              rsp_d.status = ST_ORDER; state_d = S_DONE;
            end else if (pend_fill_q == FullFill) begin
              if (commit_ok) begin
                retry_d = 1'b1; state_d = S_COPY_RD;
              end else begin
                rsp_d.status = ST_NOSPACE; state_d = S_DONE;
              end
            end else if (last_v_q &&
                         (req_q.sample_timestamp - last_t_q) < interval_q) begin
              rsp_d.status = ST_SKIPPED; state_d = S_DONE;
            end else if (pend_fill_q == FullFill - 1'b1 && !commit_ok) begin
              rsp_d.status = ST_NOSPACE; state_d = S_DONE;
            end else begin
              pw_we = 1'b1;
              pend_fill_d = pend_fill_q + 1'b1;
              pend_last_d = req_q.sample_timestamp;
              last_t_d = req_q.sample_timestamp; last_v_d = 1'b1;
              state_d = (pend_fill_q == FullFill - 1'b1) ? S_COPY_RD : S_DONE;
            end
          end
          OP_FLUSH: begin
            if (pend_fill_q == '0) state_d = S_DONE;
            else if (!commit_ok) begin
              rsp_d.status = ST_NOSPACE; state_d = S_DONE;
            end else state_d = S_COPY_RD;
          end
          OP_READ: state_d = S_RD_ISSUE;
          OP_LATEST: begin
            if (pend_fill_q != '0) rsp_d.out_timestamp = pend_last_q;
            else if (nblk_q != '0) rsp_d.out_timestamp = end_mem_q[newest];
            else rsp_d.status = ST_NOTFOUND;
            state_d = S_DONE;
          end
          OP_CLEAR: begin
            present_d = '0; pend_fill_d = '0; wslot_d = '0; nblk_d = '0;
            last_t_d = '0; last_v_d = 1'b0; end_t_d = '0; end_v_d = 1'b0;
            state_d = S_DONE;
          end
          default: begin
            rsp_d.status = ST_NOTFOUND; state_d = S_DONE;
          end
        endcase
      end
      S_COPY_RD: state_d = S_COPY_WR;
      S_COPY_WR: begin
        rw_we = 1'b1;
        pos_d = pos_q + 1'b1;
        pr_addr = pos_d[PosW-1:0];
        if (pos_d == pend_fill_q) state_d = S_COMMIT_END;
      end
      S_COMMIT_END: begin
        wr_meta = 1'b1;
        end_t_d = pend_last_q; end_v_d = 1'b1;
        present_d[wslot_q] = 1'b1;
        if (nblk_q != MaxBlocks) nblk_d = nblk_q + 1'b1;
        wslot_d = (wslot_q == LastSlot) ? '0 : wslot_q + 1'b1;
        pend_fill_d = '0; pos_d = '0;
        if (retry_q) begin
          retry_d = 1'b0;
          state_d = S_DECIDE;
        end else state_d = S_DONE;
      end
      S_RD_ISSUE: begin
        if (pos_q >= walk_fill) begin
          if (in_pend) begin
            rsp_d.status = ST_NOTFOUND; state_d = S_DONE;
          end else begin
            blk_d = blk_q + 1'b1; pos_d = '0;
          end
        end else state_d = S_RD_CHECK;
      end
      S_RD_CHECK: begin
        state_d = S_RD_ISSUE;
        pos_d = pos_q + 1'b1;
        if (walk_t >= req_q.min_timestamp) begin
          if (idx_q == '0) begin
            rsp_d.out_timestamp = walk_t; rsp_d.out_payload = walk_p;
            state_d = S_DONE;
          end else idx_d = idx_q - 1'b1;
        end
      end
      S_DONE: begin
        out_valid_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; out_valid_q <= 1'b0;
      interval_q <= 32'd300; overwrite_q <= 1'b1;
      present_q <= '0; pend_fill_q <= '0; wslot_q <= '0; nblk_q <= '0;
      last_t_q <= '0; last_v_q <= 1'b0; end_t_q <= '0; end_v_q <= 1'b0;
      retry_q <= 1'b0;
    end else begin
      state_q <= state_d; out_valid_q <= out_valid_d;
      present_q <= present_d; pend_fill_q <= pend_fill_d; wslot_q <= wslot_d;
      nblk_q <= nblk_d; last_t_q <= last_t_d; last_v_q <= last_v_d;
      end_t_q <= end_t_d; end_v_q <= end_v_d; retry_q <= retry_d;
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.data.index[CfgIdxW-1:1] == '0) begin
        if (cfg_ch.data.index[0] == REG_INTERVAL) interval_q <= cfg_ch.data.data;
        else if (cfg_ch.data.index[0] == REG_OVERWRITE) overwrite_q <= cfg_ch.data.data[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d; pos_q <= pos_d; blk_q <= blk_d; idx_q <= idx_d;
    pend_last_q <= pend_last_d;
    if (in_ch.valid && in_ch.ready) req_q <= in_ch.data;
    if (wr_meta) begin
      fill_mem_q[wslot_q] <= pend_fill_q;
      end_mem_q[wslot_q]  <= pend_last_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_fill_q <= FullFill)
    else $error("pending fill beyond block size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nblk_q <= MaxBlocks)
    else $error("stored block count beyond ring size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> state_q == S_DECIDE)
    else $error("accepted item not decoded");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_valid_q)
    else $error("result not presented");
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for the decimating sample ring logger: directed and random items on
// the item, result and register channels, checked against a built-in predictor.
// Depends on dsrl_pkg, dsrl_if and decimating_sample_ring_logger_unit.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dsrl_pkg::*;

  localparam int unsigned NSLOT = 8;
  localparam int unsigned NPER = 32;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_CODE = 3'd7;
  localparam logic [CfgIdxW-1:0] REG_NONE = 8'd2;

  class log_scoreboard;
    logic [31:0] interval;
    bit          overwrite;
    logic [31:0] ring_t[NSLOT*NPER];
    logic [63:0] ring_p[NSLOT*NPER];
    int          ring_fill[NSLOT];
    logic [31:0] ring_end[NSLOT];
    bit          present[NSLOT];
    logic [31:0] pend_t[NPER];
    logic [63:0] pend_p[NPER];
    int          pend_fill;
    int          wslot;
    int          nstored;
    logic [31:0] last_t;
    bit          last_v;
    logic [31:0] end_t;
    bit          end_v;
    rsp_t        expected_q[$];
    int          errors;

    function void empty_store();
      foreach (present[i]) present[i] = 0;
      pend_fill = 0;
      wslot = 0;
      nstored = 0;
      last_t = 0;
      last_v = 0;
      end_t = 0;
      end_v = 0;
    endfunction

    function void reset_all();
      interval = 300;
      overwrite = 1;
      errors = 0;
      empty_store();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
      if (idx == CfgIdxW'(REG_INTERVAL)) interval = val;
      else if (idx == CfgIdxW'(REG_OVERWRITE)) overwrite = val[0];
    endfunction

    function status_e commit_block();
      if (pend_fill == 0) return ST_DONE;
      if (!overwrite && present[wslot]) return ST_NOSPACE;
      for (int j = 0; j < pend_fill; j++) begin
        ring_t[wslot*NPER+j] = pend_t[j];
        ring_p[wslot*NPER+j] = pend_p[j];
      end
      ring_fill[wslot] = pend_fill;
      ring_end[wslot] = pend_t[pend_fill-1];
      end_t = ring_end[wslot];
      end_v = 1;
      present[wslot] = 1;
      if (nstored < NSLOT) nstored++;
      wslot = (wslot + 1) % NSLOT;
      pend_fill = 0;
      return ST_DONE;
    endfunction

    function status_e take_sample(logic [31:0] t, logic [63:0] p);
      logic [31:0] gap;
      if ((last_v && t < last_t) || (end_v && t < end_t)) return ST_ORDER;
      if (pend_fill >= NPER) begin
        if (commit_block() != ST_DONE) return ST_NOSPACE;
      end
      gap = t - last_t;
      if (last_v && gap < interval) return ST_SKIPPED;
      if (pend_fill == NPER - 1 && !overwrite && present[wslot]) return ST_NOSPACE;
      pend_t[pend_fill] = t;
      pend_p[pend_fill] = p;
      pend_fill++;
      last_t = t;
      last_v = 1;
      if (pend_fill == NPER) return commit_block();
      return ST_DONE;
    endfunction

    function status_e find_nth(logic [31:0] min_t, int unsigned idx,
                               output logic [31:0] t, output logic [63:0] p);
      int slot;
      t = 0;
      p = 0;
      for (int b = 0; b < nstored; b++) begin
        slot = (wslot + NSLOT - nstored + b) % NSLOT;
        for (int j = 0; j < ring_fill[slot]; j++) begin
          if (ring_t[slot*NPER+j] >= min_t) begin
            if (idx == 0) begin
              t = ring_t[slot*NPER+j];
              p = ring_p[slot*NPER+j];
              return ST_DONE;
            end
            idx--;
          end
        end
      end
      for (int j = 0; j < pend_fill; j++) begin
        if (pend_t[j] >= min_t) begin
          if (idx == 0) begin
            t = pend_t[j];
            p = pend_p[j];
            return ST_DONE;
          end
          idx--;
        end
      end
      return ST_NOTFOUND;
    endfunction

    function void note_item(req_t r);
      rsp_t e;
      status_e s;
      logic [31:0] t;
      logic [63:0] p;
      e = '0;
      case (r.op)
        OP_SAMPLE: e.status = take_sample(r.sample_timestamp, r.sample_payload);
        OP_FLUSH: e.status = commit_block();
        OP_READ: begin
          s = find_nth(r.min_timestamp, r.item_index, t, p);
          e.status = s;
          if (s == ST_DONE) begin
            e.out_timestamp = t;
            e.out_payload = p;
          end
        end
        OP_LATEST: begin
          if (pend_fill != 0) begin
            e.status = ST_DONE;
            e.out_timestamp = pend_t[pend_fill-1];
          end else if (nstored != 0) begin
            e.status = ST_DONE;
            e.out_timestamp = ring_end[(wslot + NSLOT - 1) % NSLOT];
          end else begin
            e.status = ST_NOTFOUND;
          end
        end
        OP_CLEAR: begin
          empty_store();
          e.status = ST_DONE;
        end
        default: e.status = ST_NOTFOUND;
      endcase
      expected_q.push_back(e);
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding: status %0d", a.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status);
        errors++;
      end
      if (a.out_timestamp !== e.out_timestamp) begin
        $error("out_timestamp: expected %h, got %h", e.out_timestamp, a.out_timestamp);
        errors++;
      end
      if (a.out_payload !== e.out_payload) begin
        $error("out_payload: expected %h, got %h", e.out_payload, a.out_payload);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   quiet_cycles;
  logic [31:0] now_t;
  log_scoreboard logbook;

  dsrl_if #(.T(req_t)) in_ch ();
  dsrl_if #(.T(rsp_t)) out_ch ();
  dsrl_if #(.T(cfg_t)) cfg_ch ();

  decimating_sample_ring_logger_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        logbook.note_item(in_ch.data);
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        logbook.check_result(out_ch.data);
        quiet_cycles = 0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        logbook.write_reg(cfg_ch.data.index, cfg_ch.data.data);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_item(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 0;
      @(negedge clk_i);
    end
    in_ch.valid = 1;
    in_ch.data = r;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    in_ch.valid = 0;
    cfg_ch.valid = 1;
    cfg_ch.data.index = idx;
    cfg_ch.data.data = val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 0;
  endtask

  task automatic drain();
    in_ch.valid = 0;
    while (logbook.expected_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic send_op(op_e op, logic [31:0] ts, logic [63:0] pl,
                         logic [31:0] min_t, logic [15:0] idx);
    req_t r;
    r.op = op;
    r.sample_timestamp = ts;
    r.sample_payload = pl;
    r.min_timestamp = min_t;
    r.item_index = idx;
    push_item(r);
  endtask

  task automatic send_random(logic [31:0] ivl, int clear_pct);
    req_t r;
    int   pick;
    int   span;
    span = (ivl > 50) ? 50 : int'(ivl);
    r.sample_payload = {$urandom, $urandom};
    r.sample_timestamp = $urandom;
    r.min_timestamp = $urandom;
    r.item_index = $urandom;
    pick = $urandom_range(99);
    if (pick < 70) begin
      r.op = OP_SAMPLE;
      if ($urandom_range(19) == 0) now_t = now_t - $urandom_range(0, 500);
      else now_t = now_t + $urandom_range(0, 2 * span + 3);
      r.sample_timestamp = now_t;
    end else if (pick < 78) begin
      r.op = OP_FLUSH;
    end else if (pick < 90) begin
      r.op = OP_READ;
      if ($urandom_range(1)) r.min_timestamp = 0;
      else r.min_timestamp = now_t - $urandom_range(0, 2000);
      pick = $urandom_range(99);
      if (pick < 80) r.item_index = $urandom_range(0, 40);
      else if (pick < 95) r.item_index = $urandom_range(0, 300);
      else if (pick < 97) r.item_index = 16'hFFFF;
    end else if (pick < 95) begin
      r.op = OP_LATEST;
    end else if (pick < 95 + clear_pct) begin
      r.op = OP_CLEAR;
      if ($urandom_range(1)) now_t = $urandom;
    end else begin
      r.op = op_e'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
    end
    push_item(r);
  endtask

  initial begin
    logic [31:0] ivls[6];
    bit          ows[6];
    int          counts[6];
    int          idle_p[4];
    int          stall_p[4];
    ivls = '{0, 1, 7, 300, 32'hFFFFFFFF, 3};
    ows = '{1, 0, 1, 0, 1, 0};
    counts = '{370, 370, 370, 370, 100, 370};
    idle_p = '{0, 64, 0, 22};
    stall_p = '{0, 0, 64, 22};
    logbook = new();
    logbook.reset_all();
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    now_t = 0;
    rst_ni = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    out_ch.ready = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    send_op(OP_LATEST, 0, 0, 0, 0);
    send_op(OP_READ, 0, 0, 0, 0);
    send_op(OP_FLUSH, 0, 0, 0, 0);
    send_op(OP_SAMPLE, 100, 64'hFFFFFFFFFFFFFFFF, 0, 0);
    send_op(OP_SAMPLE, 200, 64'h1, 0, 0);
    send_op(OP_SAMPLE, 50, 64'h2, 0, 0);
    send_op(OP_SAMPLE, 400, 64'hA5A5A5A55A5A5A5A, 0, 0);
    send_op(OP_LATEST, 0, 0, 0, 0);
    send_op(OP_READ, 0, 0, 0, 0);
    send_op(OP_READ, 0, 0, 0, 1);
    send_op(OP_READ, 0, 0, 0, 16'hFFFF);
    send_op(OP_READ, 0, 0, 32'hFFFFFFFF, 0);
    send_op(OP_FLUSH, 0, 0, 0, 0);
    send_op(OP_FLUSH, 0, 0, 0, 0);
    send_op(OP_LATEST, 0, 0, 0, 0);
    send_op(OP_SAMPLE, 32'hFFFFFFFF, 64'h0, 0, 0);
    send_op(OP_READ, 0, 0, 32'hFFFFFFFF, 0);
    send_op(OP_LATEST, 0, 0, 0, 0);
    send_op(OP_SAMPLE, 0, 64'h0, 0, 0);
    send_op(OP_CLEAR, 0, 0, 0, 0);
    send_op(OP_LATEST, 0, 0, 0, 0);
    send_op(OP_SAMPLE, 0, 64'h0, 0, 0);
    send_op(op_e'(OP_FIRST_UNUSED), 0, 0, 0, 0);
    send_op(op_e'(OP_LAST_CODE), 0, 0, 0, 0);
    drain();
    write_cfg(REG_NONE, 32'hFFFFFFFF);

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_op(OP_FLUSH, 0, 0, 0, 0);
      drain();
      write_cfg(CfgIdxW'(REG_INTERVAL), ivls[ph]);
      write_cfg(CfgIdxW'(REG_OVERWRITE), 32'(ows[ph]));
      send_op(OP_CLEAR, 0, 0, 0, 0);
      now_t = (ph % 2) ? $urandom : 0;
      send_idle_pct = idle_p[ph % 4];
      recv_stall_pct = stall_p[ph % 4];
      for (int n = 0; n < counts[ph]; n++) begin
        if (ph == 2 && n == counts[ph] / 2) drain();
        send_random(ivls[ph], ows[ph] ? 3 : 1);
      end
    end

    drain();
    repeat (700) @(negedge clk_i);
    if (logbook.errors == 0 && logbook.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
